[sv/psieve_pkg.sv]
// Package for the prime sieve engine: sizes, sequencer states, result and RAM request types.
// Used by every module of the block and by the response interface; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psieve_pkg;

	localparam int MAX_RANGE = 131072;
	localparam int ADDR_W    = $clog2(MAX_RANGE);
	localparam int VAL_W     = 17;
	// one spare bit so that lim+1 and x+p never wrap
	localparam int CNT_W     = ((ADDR_W > VAL_W) ? ADDR_W : VAL_W) + 1;

	localparam logic [VAL_W-1:0] LIMIT_RST = '1;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SV_RD,
		ST_SV_CHK,
		ST_MARK,
		ST_SCAN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] prime_value;
		logic             found;
		logic             last_prime;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

[sv/psieve_cmd_if.sv]
// Command channel of the prime sieve engine: valid/ready plus the restart flag.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface psieve_cmd_if;
	logic valid;
	logic ready;
	logic restart;

	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

`default_nettype wire

[sv/psieve_rsp_if.sv]
// Response channel of the prime sieve engine: valid/ready plus prime, found and last flags.
// Depends on psieve_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

interface psieve_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [psieve_pkg::VAL_W-1:0] prime_value;
	logic                        found;
	logic                        last_prime;

	modport source(output valid, output prime_value, output found, output last_prime,
		input ready);
	modport sink(input valid, input prime_value, input found, input last_prime,
		output ready);
endinterface

`default_nettype wire

[sv/psieve_mem.sv]
// One-bit-wide composite map: one write port, one read port with registered data.
// Depends on psieve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psieve_mem (
	input  wire logic                 clk,
	input  wire psieve_pkg::mem_req_t req,
	output logic                      rdata
);
	import psieve_pkg::*;

	logic mem_q [MAX_RANGE];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/psieve_alu.sv]
// Shared arithmetic unit of the sieve sequencer: one adder and one compare against the limit.
// Depends on psieve_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psieve_alu (
	input  wire psieve_pkg::cnt_t add_a,
	input  wire psieve_pkg::cnt_t add_b,
	input  wire psieve_pkg::cnt_t cmp_a,
	input  wire psieve_pkg::cnt_t lim,
	output psieve_pkg::cnt_t      sum,
	output logic                  le
);
	import psieve_pkg::*;

	assign sum = add_a + add_b;
	assign le  = (cmp_a <= lim);

endmodule

`default_nettype wire

[sv/psieve_seq.sv]
// Sequencer of the prime sieve engine: map clear, sieve marking and the prime scan.
// Depends on psieve_pkg and psieve_alu; drives the composite map through mem_req_t.
`timescale 1ns / 1ps
`default_nettype none

module psieve_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  restart,
	input  wire logic [psieve_pkg::VAL_W-1:0] limit_cfg,
	output logic                       idle,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output psieve_pkg::res_t           res,
	output psieve_pkg::mem_req_t       mem_req,
	input  wire logic                  mem_rdata
);
	import psieve_pkg::*;

	state_t state_q, state_d;
	cnt_t   lim_q, ptr_q, p_q, sq_q, pend_q, chk_n_s1;
	logic   built_q, init_q, chk_vld_s1;
	res_t   res_q;

	cnt_t   eff_lim, add_a, add_b, add_sum, cmp_a, sq_step;
	logic   cmp_le, hit, scan_end, have_pend;

	assign eff_lim = (cnt_t'(limit_cfg) > cnt_t'(MAX_RANGE - 1)) ?
		cnt_t'(MAX_RANGE - 1) : cnt_t'(limit_cfg);
	// (p+1)^2 = p^2 + 2p + 1
	assign sq_step   = {p_q[CNT_W-2:0], 1'b1};
	assign hit       = chk_vld_s1 && !mem_rdata;
	assign scan_end  = !chk_vld_s1 && !cmp_le;
	assign have_pend = built_q && (pend_q != '0);

	psieve_alu u_alu (
		.add_a (add_a),
		.add_b (add_b),
		.cmp_a (cmp_a),
		.lim   (lim_q),
		.sum   (add_sum),
		.le    (cmp_le)
	);

	// operand selection for the shared unit
	always_comb begin
		add_a = ptr_q;
		add_b = cnt_t'(1);
		cmp_a = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				add_a = pend_q;
			end
			ST_SV_RD: begin
				cmp_a = sq_q;
			end
			ST_SV_CHK: begin
				add_a = sq_q;
				add_b = sq_step;
			end
			ST_MARK: begin
				add_a = cmp_le ? ptr_q : sq_q;
				add_b = cmp_le ? p_q : sq_step;
			end
			ST_SCAN: begin
				add_a = hit ? chk_n_s1 : ptr_q;
			end
			ST_CLEAR, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (restart) state_d = ST_CLEAR;
					else if (have_pend) state_d = ST_SCAN;
					else state_d = ST_OUT;
				end
			end
			ST_CLEAR: begin
				if (ptr_q == lim_q) state_d = ST_SV_RD;
			end
			ST_SV_RD: begin
				state_d = cmp_le ? ST_SV_CHK : ST_SCAN;
			end
			ST_SV_CHK: begin
				state_d = mem_rdata ? ST_SV_RD : ST_MARK;
			end
			ST_MARK: begin
				if (!cmp_le) state_d = ST_SV_RD;
			end
			ST_SCAN: begin
				if (hit) begin
					if (!init_q) state_d = ST_OUT;
				end else if (scan_end) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		idle          = (state_q == ST_IDLE);
		res_valid     = (state_q == ST_OUT);
		mem_req.we    = (state_q == ST_CLEAR) || ((state_q == ST_MARK) && cmp_le);
		mem_req.waddr = ptr_q[ADDR_W-1:0];
		// clear pass leaves 0 and 1 marked composite
		mem_req.wdata = (state_q == ST_CLEAR) ? (ptr_q < cnt_t'(2)) : 1'b1;
		mem_req.raddr = (state_q == ST_SV_RD) ? p_q[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			built_q    <= 1'b0;
			init_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
			pend_q     <= '0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= (state_q == ST_SCAN) && cmp_le && !hit;
			unique case (state_q)
				ST_IDLE: begin
					if (start && (restart || !have_pend)) built_q <= 1'b0;
				end
				ST_SV_RD: begin
					if (!cmp_le) init_q <= 1'b1;
				end
				ST_SCAN: begin
					if (init_q) begin
						if (hit) begin
							init_q  <= 1'b0;
							built_q <= 1'b1;
						end else if (scan_end) begin
							init_q <= 1'b0;
						end
					end else if (hit) begin
						pend_q <= chk_n_s1;
					end else if (scan_end) begin
						pend_q  <= '0;
						built_q <= 1'b0;
					end
				end
				ST_CLEAR, ST_SV_CHK, ST_MARK, ST_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		chk_n_s1 <= ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (restart) begin
						lim_q <= eff_lim;
						ptr_q <= '0;
					end else begin
						ptr_q <= add_sum;
						res_q.prime_value <= have_pend ? pend_q[VAL_W-1:0] : '0;
						res_q.found       <= have_pend;
						res_q.last_prime  <= 1'b0;
					end
				end
			end
			ST_CLEAR: begin
				ptr_q <= add_sum;
				if (ptr_q == lim_q) begin
					p_q  <= cnt_t'(2);
					sq_q <= cnt_t'(4);
				end
			end
			ST_SV_RD: begin
				if (!cmp_le) ptr_q <= cnt_t'(2);
			end
			ST_SV_CHK: begin
				if (mem_rdata) begin
					p_q  <= p_q + cnt_t'(1);
					sq_q <= add_sum;
				end else begin
					ptr_q <= sq_q;
				end
			end
			ST_MARK: begin
				if (cmp_le) begin
					ptr_q <= add_sum;
				end else begin
					p_q  <= p_q + cnt_t'(1);
					sq_q <= add_sum;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					ptr_q <= add_sum;
					if (init_q) begin
						res_q.prime_value <= chk_n_s1[VAL_W-1:0];
						res_q.found       <= 1'b1;
						res_q.last_prime  <= 1'b0;
					end
				end else if (scan_end) begin
					if (init_q) res_q <= '0;
					else res_q.last_prime <= 1'b1;
				end else if (cmp_le) begin
					ptr_q <= add_sum;
				end
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

[sv/prime_sieve_engine_top.sv]
// Prime sieve engine: an Eratosthenes sieve over a one-bit map, handing out primes in order.
// Channel cmd takes a restart flag; each transaction there returns one transaction on rsp.
// The sieve_limit register (cfg_we/cfg_wdata) sets the top of the range; it takes effect
// at the next restart and saturates at MAX_RANGE-1.
// A restart transaction clears map entries 0..limit, then sieves: for each candidate p with
// p*p <= limit it reads the map entry of p and, if p is prime, marks each multiple from p*p,
// then scans for the first prime.
// Every transaction that holds a next prime (after the restart work, if any) scans from it to
// the one after it, one map read per cycle through the single RAM read port; a fetch with no
// held prime does not scan. The scan one prime ahead sets the last_prime flag.
// cmd.ready is high only while the sequencer is idle. The result goes to an output register,
// so a new command is taken while rsp waits; a stalled rsp holds the next result in the
// sequencer until the register frees.
// Reset clears the control state and sets the limit to 131071; no sieve is built, so fetches
// return found=0 until a restart. The map itself has no reset.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_engine_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	psieve_cmd_if.sink                        cmd,
	psieve_rsp_if.source                      rsp,
	input  wire logic                         cfg_we,
	input  wire logic [psieve_pkg::VAL_W-1:0] cfg_wdata
);
	import psieve_pkg::*;

	logic [VAL_W-1:0] limit_q;
	logic             out_vld_q;
	res_t             out_q;

	logic     idle, start, res_valid, res_ready;
	res_t     res;
	mem_req_t mem_req;
	logic     mem_rdata;

	assign start     = cmd.valid && idle;
	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RST;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (res_valid && res_ready) out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	psieve_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.restart   (cmd.restart),
		.limit_cfg (limit_q),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	psieve_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign cmd.ready       = idle;
	assign rsp.valid       = out_vld_q;
	assign rsp.prime_value = out_q.prime_value;
	assign rsp.found       = out_q.found;
	assign rsp.last_prime  = out_q.last_prime;

endmodule

`default_nettype wire

[sv/psieve_chk.sv]
// Port-level checks for prime_sieve_engine_top, attached by the bind at the end of the file.
// Depends on psieve_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

module psieve_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [psieve_pkg::VAL_W-1:0] prime_value,
	input wire logic                         found,
	input wire logic                         last_prime
);
	import psieve_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime_value) && $stable(found)
			&& $stable(last_prime))
		else $error("rsp transaction changed while stalled");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> prime_value == '0 && !last_prime)
		else $error("exhausted result carries a value or last flag");

	a_prime_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> prime_value >= VAL_W'(2))
		else $error("returned prime below two");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("cmd taken while previous transaction in work");

endmodule

bind prime_sieve_engine_top psieve_chk u_psieve_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd.valid),
	.in_ready    (cmd.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.prime_value (rsp.prime_value),
	.found       (rsp.found),
	.last_prime  (rsp.last_prime)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for prime_sieve_engine_top: directed and random restart/fetch traffic
// with bursty commands, a stalling response sink and an in-bench sieve predictor.
// Depends on psieve_pkg, psieve_cmd_if, psieve_rsp_if and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
	import psieve_pkg::*;

	localparam int RANDOM_ITEMS   = 1150;
	localparam int WATCHDOG_LIMIT = 2000000;
	localparam int REPORT_MAX     = 10;
	localparam logic [VAL_W-1:0] LIMIT_TOP = '1;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_CADENCE,
		RDY_RANDOM,
		RDY_BLOCKS
	} rdy_mode_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [VAL_W-1:0] cfg_wdata;

	psieve_cmd_if cmd_ch();
	psieve_rsp_if rsp_ch();

	prime_sieve_engine_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predictor state: composite flags, latched limit, scan position
	bit               composite_bits [MAX_RANGE];
	logic [VAL_W-1:0] limit_reg;
	int unsigned      sieve_top;
	int unsigned      scan_pos;
	bit               primes_left;

	res_t expected_primes[$];
	res_t want;
	int   mismatch_count;
	int   burst_left;
	int   idle_cycles;

	rdy_mode_t rdy_mode;
	int        rdy_mode_left;
	int        rdy_hold;
	int        rdy_tick;

	function automatic void build_composite_map();
		int unsigned lim;
		int unsigned n;
		int unsigned p;
		lim = limit_reg;
		if (lim > MAX_RANGE - 1)
			lim = MAX_RANGE - 1;
		for (n = 0; n <= lim; n++)
			composite_bits[n] = 1'b0;
		composite_bits[0] = 1'b1;
		if (lim >= 1)
			composite_bits[1] = 1'b1;
		for (p = 2; p * p <= lim; p++) begin
			if (!composite_bits[p]) begin
				for (n = p * p; n <= lim; n += p)
					composite_bits[n] = 1'b1;
			end
		end
		sieve_top   = lim;
		scan_pos    = 2;
		primes_left = 1'b1;
	endfunction

	function automatic int unsigned first_prime_from(input int unsigned from);
		int unsigned n;
		for (n = from; n <= sieve_top; n++) begin
			if (n >= 2 && !composite_bits[n])
				return n;
		end
		return 0;
	endfunction

	function automatic res_t predict_prime(input logic do_restart);
		res_t        r;
		int unsigned p;
		int unsigned after;
		r = '0;
		if (do_restart)
			build_composite_map();
		if (primes_left) begin
			p = first_prime_from(scan_pos);
			if (p != 0) begin
				after         = (p < sieve_top) ? first_prime_from(p + 1) : 0;
				r.prime_value = p[VAL_W-1:0];
				r.found       = 1'b1;
				r.last_prime  = (after == 0);
				scan_pos      = (p + 1) & LIMIT_TOP;
				if (after == 0)
					primes_left = 1'b0;
			end else begin
				primes_left = 1'b0;
			end
		end
		return r;
	endfunction

	// one command transaction; valid stays high across a burst
	task automatic send_cmd(input logic do_restart);
		int gap;
		cmd_ch.valid   <= 1'b1;
		cmd_ch.restart <= do_restart;
		do @(posedge clk); while (!cmd_ch.ready);
		expected_primes = {expected_primes, predict_prime(do_restart)};
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_ch.valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_primes.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [VAL_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		limit_reg = value;
	endtask

	task automatic test_fetch_before_restart();
		send_cmd(1'b0);
		send_cmd(1'b0);
	endtask

	task automatic test_full_range();
		write_limit(LIMIT_TOP);
		send_cmd(1'b1);
		repeat (3) send_cmd(1'b0);
	endtask

	// new limit lands only at the next restart; also runs the scan to exhaustion
	task automatic test_deferred_limit();
		write_limit(30);
		send_cmd(1'b1);
		send_cmd(1'b0);
		write_limit(10);
		repeat (9) send_cmd(1'b0);
		send_cmd(1'b1);
	endtask

	task automatic test_tiny_limits();
		write_limit(0);
		send_cmd(1'b1);
		send_cmd(1'b0);
		write_limit(1);
		send_cmd(1'b1);
		write_limit(2);
		send_cmd(1'b1);
		send_cmd(1'b0);
		write_limit(3);
		send_cmd(1'b1);
		send_cmd(1'b0);
	endtask

	task automatic test_random_phases();
		int          sent;
		int          n_items;
		int          sel;
		int          i;
		logic [VAL_W-1:0] lim;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				lim = VAL_W'($urandom_range(0, 3));
			else if (sel < 70)
				lim = VAL_W'($urandom_range(4, 200));
			else if (sel < 96)
				lim = VAL_W'($urandom_range(201, 3000));
			else
				lim = VAL_W'($urandom_range(3001, 20000));
			write_limit(lim);
			// stray fetches ahead of the restart now and then
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_cmd(1'b0);
					sent++;
				end
			end
			send_cmd(1'b1);
			sent++;
			n_items = $urandom_range(10, 70);
			for (i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 49) == 0)
					write_limit(VAL_W'($urandom_range(0, 300)));
				send_cmd($urandom_range(0, 29) == 0);
				sent++;
			end
		end
	endtask

	// response sink, whose stall pattern switches at random among four modes
	always @(negedge clk) begin
		if (rdy_mode_left == 0) begin
			rdy_mode      = rdy_mode_t'($urandom_range(0, 3));
			rdy_mode_left = $urandom_range(16, 96);
		end else begin
			rdy_mode_left--;
		end
		case (rdy_mode)
			RDY_ALWAYS: rsp_ch.ready <= 1'b1;
			RDY_CADENCE: rsp_ch.ready <= (rdy_tick % 4 != 3);
			RDY_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: begin
				if (rdy_hold > 0) begin
					rdy_hold--;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
					rdy_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : 0;
				end
			end
		endcase
		rdy_tick++;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_primes.size() == 0) begin
				if (mismatch_count < REPORT_MAX)
					$display("unexpected result transaction: prime=%0d found=%0b last=%0b",
						rsp_ch.prime_value, rsp_ch.found, rsp_ch.last_prime);
				mismatch_count++;
			end else begin
				want = expected_primes.pop_front();
				if (rsp_ch.prime_value !== want.prime_value || rsp_ch.found !== want.found
					|| rsp_ch.last_prime !== want.last_prime) begin
					if (mismatch_count < REPORT_MAX)
						$display("mismatch: expected prime=%0d found=%0b last=%0b, got prime=%0d found=%0b last=%0b",
							want.prime_value, want.found, want.last_prime,
							rsp_ch.prime_value, rsp_ch.found, rsp_ch.last_prime);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("prime_sieve_engine_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.restart = 1'b0;
		rsp_ch.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		limit_reg      = LIMIT_RST;
		sieve_top      = 0;
		scan_pos       = 0;
		primes_left    = 1'b0;
		mismatch_count = 0;
		idle_cycles    = 0;
		burst_left     = $urandom_range(0, 12);
		rdy_mode       = RDY_ALWAYS;
		rdy_mode_left  = 0;
		rdy_hold       = 0;
		rdy_tick       = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fetch_before_restart();
		test_full_range();
		test_deferred_limit();
		test_tiny_limits();
		test_random_phases();

		drain();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("prime_sieve_engine_top verification clean");
		end else begin
			$display("prime_sieve_engine_top verification failed");
		end
		$finish;
	end

endmodule

[files.f]
sv/psieve_pkg.sv
sv/psieve_cmd_if.sv
sv/psieve_rsp_if.sv
sv/psieve_mem.sv
sv/psieve_alu.sv
sv/psieve_seq.sv
sv/prime_sieve_engine_top.sv
sv/psieve_chk.sv
sim/tb_top.sv
